FILE: hw/rtl/csu_pkg.sv
// Shared types and constants for the cosine similarity unit.
// Holds the element pair, result and queued sum words.
// No dependencies.
package csu_pkg;

    localparam int ELEMENT_BITS       = 16;
    localparam int PROD_BITS          = 2 * ELEMENT_BITS;
    localparam int ACC_BITS           = 48;
    localparam int ROOT_BITS          = ACC_BITS / 2;
    localparam int FRAC_BITS          = 15;
    localparam int QUEUE_DEPTH        = 2;
    localparam int QUEUE_COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_LENGTH_DEFAULT = 4096;

    typedef struct packed {
        logic signed [ELEMENT_BITS-1:0] a_element;
        logic signed [ELEMENT_BITS-1:0] b_element;
        logic                           last_element;
    } csu_pair_t;

    typedef struct packed {
        logic signed [ELEMENT_BITS-1:0] similarity;
        logic                           zero_norm;
        logic                           too_long;
    } csu_result_t;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] dot_sum;
        logic [ACC_BITS-1:0]        norm_a_sum;
        logic [ACC_BITS-1:0]        norm_b_sum;
        logic                       too_long;
    } csu_sums_t;

endpackage

FILE: hw/rtl/csu_front.sv
// Front end: takes element pairs, registers the products and accumulates
// dot product and squared norms; pushes the sums on the last pair.
// Depends on csu_pkg.
module csu_front
    import csu_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pair_valid,
    output logic                        pair_ready,
    input  csu_pair_t                   pair_word,
    input  logic [QUEUE_COUNT_BITS-1:0] queue_count,
    output logic                        push,
    output csu_sums_t                   push_word
);

    localparam int CW = $clog2(MAX_LENGTH + 2);
    localparam logic [CW-1:0] LIMIT = CW'(MAX_LENGTH);

    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [CW-1:0]              count_inc;
    logic                       accept;
    logic                       pending;

    logic                       s1_valid_reg;
    logic                       s1_last_reg;
    logic                       s1_use_reg;
    logic                       s1_over_reg;
    logic signed [PROD_BITS-1:0] dot_p_reg;
    logic [PROD_BITS-1:0]       sq_a_reg;
    logic [PROD_BITS-1:0]       sq_b_reg;

    logic signed [ACC_BITS-1:0] dot_reg;
    logic [ACC_BITS-1:0]        na_reg;
    logic [ACC_BITS-1:0]        nb_reg;
    logic signed [ACC_BITS-1:0] dot_total;
    logic [ACC_BITS-1:0]        na_total;
    logic [ACC_BITS-1:0]        nb_total;

    assign pending    = s1_valid_reg & s1_last_reg;
    assign pair_ready = (QUEUE_COUNT_BITS'(queue_count + QUEUE_COUNT_BITS'(pending))
                         < QUEUE_COUNT_BITS'(QUEUE_DEPTH));
    assign accept     = pair_valid & pair_ready;
    assign count_inc  = count_reg + CW'(count_reg <= LIMIT);

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = pair_word.last_element ? '0 : count_inc;
        end
    end

    always_comb
    begin
        dot_total = dot_reg;
        na_total  = na_reg;
        nb_total  = nb_reg;
        if (s1_use_reg)
        begin
            dot_total = dot_reg + ACC_BITS'(dot_p_reg);
            na_total  = na_reg + ACC_BITS'(sq_a_reg);
            nb_total  = nb_reg + ACC_BITS'(sq_b_reg);
        end
    end

    assign push                 = pending;
    assign push_word.dot_sum    = dot_total;
    assign push_word.norm_a_sum = na_total;
    assign push_word.norm_b_sum = nb_total;
    assign push_word.too_long   = s1_over_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_use_reg   <= 1'b0;
            s1_over_reg  <= 1'b0;
            dot_reg      <= '0;
            na_reg       <= '0;
            nb_reg       <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            s1_valid_reg <= accept;
            s1_last_reg  <= pair_word.last_element;
            s1_use_reg   <= accept && (count_reg < LIMIT);
            s1_over_reg  <= count_inc > LIMIT;
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    dot_reg <= '0;
                    na_reg  <= '0;
                    nb_reg  <= '0;
                end
                else
                begin
                    dot_reg <= dot_total;
                    na_reg  <= na_total;
                    nb_reg  <= nb_total;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dot_p_reg <= PROD_BITS'(pair_word.a_element) * PROD_BITS'(pair_word.b_element);
        sq_a_reg  <= PROD_BITS'(pair_word.a_element) * PROD_BITS'(pair_word.a_element);
        sq_b_reg  <= PROD_BITS'(pair_word.b_element) * PROD_BITS'(pair_word.b_element);
    end

endmodule

FILE: hw/rtl/csu_queue.sv
// Short queue of finished sums between front and back end.
// Register based, one push and one pop per cycle.
// Depends on csu_pkg.
module csu_queue
    import csu_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  csu_sums_t                   push_word,
    input  logic                        pop,
    output logic                        head_valid,
    output csu_sums_t                   head_word,
    output logic [QUEUE_COUNT_BITS-1:0] count
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    csu_sums_t                   entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]               wr_ptr_reg;
    logic [PW-1:0]               rd_ptr_reg;
    logic [QUEUE_COUNT_BITS-1:0] count_reg;
    logic                        do_pop;

    assign head_valid = count_reg != '0;
    assign head_word  = entry_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop & head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QUEUE_COUNT_BITS'(push) - QUEUE_COUNT_BITS'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: hw/rtl/csu_back.sv
// Back end: square roots of both norms a bit per cycle, one multiply,
// then a restoring divide with saturation into the result register.
// Depends on csu_pkg.
module csu_back
    import csu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  csu_sums_t   head_word,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_ready,
    output csu_result_t result_word
);

    localparam int RW = ROOT_BITS + 3;
    localparam int SW = $clog2(ROOT_BITS);
    localparam int QW = FRAC_BITS + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_MUL,
        ST_SETUP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [RW-1:0]        rem;
        logic [ROOT_BITS-1:0] root;
    } root_step_t;

    function automatic root_step_t root_step(input logic [RW-1:0] rem,
                                             input logic [ROOT_BITS-1:0] root,
                                             input logic [1:0] bits);
        root_step_t    res;
        logic [RW-1:0] cur;
        logic [RW-1:0] trial;
        cur   = {rem[RW-3:0], bits};
        trial = RW'({root, 2'b01});
        if (cur >= trial)
        begin
            res.rem  = cur - trial;
            res.root = {root[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            res.rem  = cur;
            res.root = {root[ROOT_BITS-2:0], 1'b0};
        end
        return res;
    endfunction

    state_t                  state_reg;
    logic [SW-1:0]           step_reg;
    logic [ACC_BITS-1:0]     na_shift_reg;
    logic [ACC_BITS-1:0]     nb_shift_reg;
    logic [RW-1:0]           ra_reg;
    logic [RW-1:0]           rb_reg;
    logic [ROOT_BITS-1:0]    root_a_reg;
    logic [ROOT_BITS-1:0]    root_b_reg;
    logic [ACC_BITS-1:0]     den_reg;
    logic [ACC_BITS-1:0]     mag_reg;
    logic [ACC_BITS:0]       rem_reg;
    logic [QW-1:0]           quo_reg;
    logic                    neg_reg;
    logic                    zero_reg;
    logic                    long_reg;
    logic                    sat_reg;
    logic                    result_valid_reg;
    csu_result_t             result_word_reg;

    root_step_t              step_a;
    root_step_t              step_b;
    logic                    div_ge;
    logic [ACC_BITS:0]       div_diff;
    logic [QW-1:0]           q_final;
    logic signed [QW-1:0]    sim;
    logic                    load_result;

    assign pop          = (state_reg == ST_IDLE) && head_valid;
    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;
    assign load_result  = (state_reg == ST_FINISH) && (!result_valid_reg || result_ready);

    assign step_a   = root_step(ra_reg, root_a_reg, na_shift_reg[ACC_BITS-1 -: 2]);
    assign step_b   = root_step(rb_reg, root_b_reg, nb_shift_reg[ACC_BITS-1 -: 2]);
    assign div_ge   = rem_reg >= {1'b0, den_reg};
    assign div_diff = div_ge ? rem_reg - {1'b0, den_reg} : rem_reg;

    always_comb
    begin
        if (neg_reg)
        begin
            q_final = (sat_reg || quo_reg > {1'b1, {(QW-1){1'b0}}})
                      ? {1'b1, {(QW-1){1'b0}}} : quo_reg;
            sim     = QW'(0) - q_final;
        end
        else
        begin
            q_final = (sat_reg || quo_reg[QW-1]) ? {1'b0, {(QW-1){1'b1}}} : quo_reg;
            sim     = q_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            na_shift_reg     <= '0;
            nb_shift_reg     <= '0;
            ra_reg           <= '0;
            rb_reg           <= '0;
            root_a_reg       <= '0;
            root_b_reg       <= '0;
            den_reg          <= '0;
            mag_reg          <= '0;
            rem_reg          <= '0;
            quo_reg          <= '0;
            neg_reg          <= 1'b0;
            zero_reg         <= 1'b0;
            long_reg         <= 1'b0;
            sat_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            result_word_reg  <= '0;
        end
        else
        begin
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        na_shift_reg <= head_word.norm_a_sum;
                        nb_shift_reg <= head_word.norm_b_sum;
                        ra_reg       <= '0;
                        rb_reg       <= '0;
                        root_a_reg   <= '0;
                        root_b_reg   <= '0;
                        neg_reg      <= head_word.dot_sum[ACC_BITS-1];
                        mag_reg      <= head_word.dot_sum[ACC_BITS-1]
                                        ? ACC_BITS'(0) - head_word.dot_sum
                                        : head_word.dot_sum;
                        zero_reg     <= (head_word.norm_a_sum == '0)
                                        || (head_word.norm_b_sum == '0);
                        long_reg     <= head_word.too_long;
                        step_reg     <= SW'(ROOT_BITS - 1);
                        state_reg    <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    ra_reg       <= step_a.rem;
                    rb_reg       <= step_b.rem;
                    root_a_reg   <= step_a.root;
                    root_b_reg   <= step_b.root;
                    na_shift_reg <= {na_shift_reg[ACC_BITS-3:0], 2'b00};
                    nb_shift_reg <= {nb_shift_reg[ACC_BITS-3:0], 2'b00};
                    step_reg     <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    den_reg   <= root_a_reg * root_b_reg;
                    state_reg <= ST_SETUP;
                end
                ST_SETUP:
                begin
                    sat_reg   <= {1'b0, mag_reg} >= {den_reg, 1'b0};
                    rem_reg   <= {1'b0, mag_reg};
                    quo_reg   <= '0;
                    step_reg  <= SW'(FRAC_BITS);
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    quo_reg  <= {quo_reg[QW-2:0], div_ge};
                    rem_reg  <= {div_diff[ACC_BITS-1:0], 1'b0};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (load_result)
                    begin
                        result_word_reg.similarity <= zero_reg ? '0 : sim;
                        result_word_reg.zero_norm  <= zero_reg;
                        result_word_reg.too_long   <= long_reg;
                        state_reg                  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/cosine_similarity_unit.sv
// Cosine similarity of two streamed vectors, signed Q1.15 in and out.
// Throughput: one element pair per cycle while pair_ready is high (it drops
// as the queue fills); the back end works out each result after the last
// pair in 24 root steps, a multiply and 16 divide steps, one vector at a time;
// a 2-entry queue lets accumulation of the next vector overlap. Reset (rst_n,
// async) clears the accumulators, the queue and the result register.
module cosine_similarity_unit
    import csu_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pair_valid,
    output logic        pair_ready,
    input  csu_pair_t   pair_word,
    output logic        result_valid,
    input  logic        result_ready,
    output csu_result_t result_word
);

    logic                        push;
    csu_sums_t                   push_word;
    logic                        pop;
    logic                        head_valid;
    csu_sums_t                   head_word;
    logic [QUEUE_COUNT_BITS-1:0] queue_count;

    csu_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pair_valid  (pair_valid),
        .pair_ready  (pair_ready),
        .pair_word   (pair_word),
        .queue_count (queue_count),
        .push        (push),
        .push_word   (push_word)
    );

    csu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .pop        (pop),
        .head_valid (head_valid),
        .head_word  (head_word),
        .count      (queue_count)
    );

    csu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_word    (head_word),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

endmodule

FILE: verif/cosine_similarity_unit_tb.sv
// Self-checking testbench for cosine_similarity_unit: streams vector pairs
// with random idling and compares every result word against a bit-true predictor.
// Depends on csu_pkg and the cosine_similarity_unit RTL.
`timescale 1ns / 100ps

module cosine_similarity_unit_tb;
    import csu_pkg::*;

    localparam int MAX_PAIRS = MAX_LENGTH_DEFAULT;
    localparam int RANDOM_PAIRS = 930;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_e;

    class similarity_scoreboard;
        logic [ACC_BITS-1:0] dot_acc;
        logic [ACC_BITS-1:0] norm_a_acc;
        logic [ACC_BITS-1:0] norm_b_acc;
        int unsigned         pair_count;
        int unsigned         max_pairs;
        int unsigned         error_count;
        csu_result_t         expected_results[$];

        function new(int unsigned max_len);
            max_pairs   = max_len;
            error_count = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            dot_acc    = '0;
            norm_a_acc = '0;
            norm_b_acc = '0;
            pair_count = 0;
        endfunction

        function longint unsigned root_floor(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_pair(csu_pair_t p);
            longint              av;
            longint              bv;
            longint unsigned     den;
            longint unsigned     mag;
            longint unsigned     quo;
            logic [ACC_BITS-1:0] dot_mag;
            logic                neg;
            csu_result_t         res;
            av = longint'($signed(p.a_element));
            bv = longint'($signed(p.b_element));
            if (pair_count < max_pairs)
            begin
                dot_acc    = dot_acc + ACC_BITS'(av * bv);
                norm_a_acc = norm_a_acc + ACC_BITS'(av * av);
                norm_b_acc = norm_b_acc + ACC_BITS'(bv * bv);
            end
            if (pair_count <= max_pairs)
                pair_count++;
            if (!p.last_element)
                return;
            res = '0;
            res.too_long = (pair_count > max_pairs);
            if (norm_a_acc == 0 || norm_b_acc == 0)
                res.zero_norm = 1'b1;
            else
            begin
                den     = root_floor(64'(norm_a_acc)) * root_floor(64'(norm_b_acc));
                neg     = dot_acc[ACC_BITS-1];
                dot_mag = neg ? (ACC_BITS'(0) - dot_acc) : dot_acc;
                mag     = 64'(dot_mag);
                quo     = (mag << FRAC_BITS) / den;
                if (neg)
                begin
                    if (quo > 64'd32768)
                        quo = 64'd32768;
                    quo = 64'h10000 - quo;
                end
                else if (quo > 64'd32767)
                    quo = 64'd32767;
                res.similarity = quo[ELEMENT_BITS-1:0];
            end
            expected_results = {expected_results, res};
            clear_sums();
        endfunction

        function void check_result(csu_result_t got);
            csu_result_t exp_res;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result word: similarity %0d zero_norm %0d too_long %0d",
                       got.similarity, got.zero_norm, got.too_long);
                error_count++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (got.similarity !== exp_res.similarity)
            begin
                $error("similarity: expected %0d, actual %0d",
                       exp_res.similarity, got.similarity);
                error_count++;
            end
            if (got.zero_norm !== exp_res.zero_norm)
            begin
                $error("zero_norm: expected %0d, actual %0d", exp_res.zero_norm, got.zero_norm);
                error_count++;
            end
            if (got.too_long !== exp_res.too_long)
            begin
                $error("too_long: expected %0d, actual %0d", exp_res.too_long, got.too_long);
                error_count++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        pair_valid;
    logic        pair_ready;
    csu_pair_t   pair_word;
    logic        result_valid;
    logic        result_ready;
    csu_result_t result_word;

    similarity_scoreboard sb;

    int unsigned burst_left;
    bit          no_gaps;
    bit          rx_hold_request;
    int unsigned random_sent;

    cosine_similarity_unit #(
        .MAX_LENGTH (MAX_PAIRS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_ready   (pair_ready),
        .pair_word    (pair_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("cosine_similarity_unit_tb: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && pair_valid && pair_ready)
            sb.note_pair(pair_word);
        if (rst_n && result_valid && result_ready)
            sb.check_result(result_word);
    end

    initial
    begin
        rx_mode_e    rx_mode;
        int unsigned mode_left;
        int unsigned hold_left;
        rx_mode      = RX_OPEN;
        mode_left    = 0;
        hold_left    = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_request)
            begin
                rx_hold_request = 1'b0;
                hold_left       = 400;
            end
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:   result_ready <= 1'b1;
                    RX_MOSTLY: result_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                    default:   result_ready <= ~result_ready;
                endcase
            end
        end
    end

    function automatic csu_pair_t make_pair(int a, int b, bit last);
        csu_pair_t p;
        p.a_element    = ELEMENT_BITS'(a);
        p.b_element    = ELEMENT_BITS'(b);
        p.last_element = last;
        return p;
    endfunction

    task automatic send_pair(input csu_pair_t p);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
            if (!no_gaps && gap != 0)
            begin
                pair_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pair_valid <= 1'b1;
        pair_word  <= p;
        do
            @(posedge clk);
        while (!pair_ready);
    endtask

    task automatic wait_results_done();
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_vector();
        int unsigned len;
        int unsigned style;
        int          a;
        int          b;
        len   = ($urandom_range(0, 19) < 16) ? $urandom_range(1, 12) :
                ($urandom_range(0, 3) != 0) ? $urandom_range(13, 64) : $urandom_range(65, 200);
        style = $urandom_range(0, 9);
        for (int unsigned i = 0; i < len; i++)
        begin
            a = (style == 5 || style == 6) ? $urandom_range(0, 31) - 16 :
                $urandom_range(0, 65535) - 32768;
            if ($urandom_range(0, 15) == 0)
                a = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            case (style)
                7:       b = a;
                8:       b = -a;
                9:       b = $urandom_range(0, 65535) - 32768;
                5, 6:    b = $urandom_range(0, 31) - 16;
                default: b = $urandom_range(0, 65535) - 32768;
            endcase
            if (style == 9)
                a = 0;
            send_pair(make_pair(a, b, i == len - 1));
            random_sent++;
        end
    endtask

    initial
    begin
        csu_pair_t   directed[$];
        bit          hold_done;
        bit          drain_done;
        int unsigned hold_until;

        rst_n           <= 1'b0;
        pair_valid      <= 1'b0;
        pair_word       <= '0;
        burst_left      = 0;
        no_gaps         = 1'b0;
        rx_hold_request = 1'b0;
        random_sent     = 0;
        hold_done       = 1'b0;
        drain_done      = 1'b0;
        hold_until      = 0;
        sb              = new(MAX_PAIRS);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = {make_pair(32767, 32767, 1'b1),
                    make_pair(-32768, -32768, 1'b1),
                    make_pair(-32768, 32767, 1'b1),
                    make_pair(32767, -32768, 1'b1),
                    make_pair(0, 5, 1'b1),
                    make_pair(7, 0, 1'b1),
                    make_pair(0, 0, 1'b1),
                    make_pair(1, 0, 1'b0),
                    make_pair(0, 1, 1'b1),
                    make_pair(16384, 16384, 1'b0),
                    make_pair(-16384, 16384, 1'b1),
                    make_pair(21845, -21846, 1'b0),
                    make_pair(-1, 1, 1'b0),
                    make_pair(1, -1, 1'b1),
                    make_pair(1, 1, 1'b1),
                    make_pair(1, -1, 1'b1),
                    make_pair(-32768, 0, 1'b0),
                    make_pair(0, -32768, 1'b1),
                    make_pair(3, 4, 1'b0),
                    make_pair(4, -3, 1'b0),
                    make_pair(-32768, -32768, 1'b1)};
        foreach (directed[i])
            send_pair(directed[i]);

        while (random_sent < RANDOM_PAIRS)
        begin
            if (!hold_done && random_sent >= 300)
            begin
                hold_done       = 1'b1;
                rx_hold_request = 1'b1;
                no_gaps         = 1'b1;
                hold_until      = random_sent + 120;
            end
            if (no_gaps && random_sent >= hold_until)
                no_gaps = 1'b0;
            if (!drain_done && random_sent >= 650)
            begin
                drain_done = 1'b1;
                pair_valid <= 1'b0;
                burst_left = 0;
                @(posedge clk);
                wait_results_done();
            end
            send_random_vector();
        end

        pair_valid <= 1'b0;
        @(posedge clk);
        wait_results_done();
        repeat (60) @(posedge clk);
        if (sb.error_count == 0 && sb.expected_results.size() == 0)
            $display("cosine_similarity_unit_tb: clean");
        else
            $display("cosine_similarity_unit_tb: errors");
        $finish;
    end

endmodule
